[hdl/mnps_pkg.sv]
// ----------------------------------------------------------------------------
// Masked nearest point search: shared definitions
// Widths, operation codes, the control state type and the record types used
// by the channels, the memories and the squared-distance pipeline.
// ----------------------------------------------------------------------------
package mnps_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int MAX_SLOTS  = 1024;
   localparam int PIDX_W     = $clog2(MAX_POINTS);
   localparam int SIDX_W     = $clog2(MAX_SLOTS);
   localparam int LEN_W      = 11;
   localparam int COORD_W    = 32;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DSQ_W      = SQ_W + 1;

   // Operation codes of the mode field. The fourth code is a no-op.
   localparam logic [1:0] MODE_WR_POINT = 2'd0;
   localparam logic [1:0] MODE_WR_SLOT  = 2'd1;
   localparam logic [1:0] MODE_QUERY    = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } mnps_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } mnps_point_type;

   typedef struct packed {
      logic              masked;
      logic [PIDX_W-1:0] idx;
   } mnps_slot_type;

   typedef struct packed {
      logic [PIDX_W-1:0] idx;
      mnps_point_type    pt;
   } mnps_cand_type;

endpackage

[hdl/mnps_channels.sv]
// ----------------------------------------------------------------------------
// Masked nearest point search: channel interfaces
// Valid/ready channels for request transactions and response transactions.
// ----------------------------------------------------------------------------
interface mnps_req_if import mnps_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic [PIDX_W-1:0]         point_index;
   logic [SIDX_W-1:0]         slot_index;
   logic                      slot_masked;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic signed [COORD_W-1:0] query_lat;
   logic signed [COORD_W-1:0] query_lon;

   modport source (
      output valid, mode, point_index, slot_index, slot_masked,
             point_x, point_y, point_z, query_lat, query_lon,
      input  ready
   );

   modport sink (
      input  valid, mode, point_index, slot_index, slot_masked,
             point_x, point_y, point_z, query_lat, query_lon,
      output ready
   );
endinterface

interface mnps_rsp_if import mnps_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [PIDX_W-1:0]         nearest_index;
   logic signed [COORD_W-1:0] nearest_x;
   logic signed [COORD_W-1:0] nearest_y;
   logic signed [COORD_W-1:0] nearest_z;

   modport source (
      output valid, found, nearest_index, nearest_x, nearest_y, nearest_z,
      input  ready
   );

   modport sink (
      input  valid, found, nearest_index, nearest_x, nearest_y, nearest_z,
      output ready
   );
endinterface

[hdl/mnps_sqdist.sv]
// ----------------------------------------------------------------------------
// Masked nearest point search: squared planar distance pipeline
// Three registered stages: absolute differences, squares, and the 65-bit sum.
// ----------------------------------------------------------------------------
module mnps_sqdist import mnps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  mnps_cand_type             in_cand,
   input  logic signed [COORD_W-1:0] query_lat,
   input  logic signed [COORD_W-1:0] query_lon,
   output logic                      out_valid,
   output mnps_cand_type             out_cand,
   output logic [DSQ_W-1:0]          out_dsq,
   output logic                      busy
);

   // The difference of two 32-bit signed values has a magnitude below 2^32.
   function automatic logic [COORD_W-1:0] abs_diff(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

   logic               a_valid_ff, b_valid_ff, c_valid_ff;
   mnps_cand_type      a_cand_ff, b_cand_ff, c_cand_ff;
   logic [COORD_W-1:0] a_dx_ff, a_dy_ff;
   logic [SQ_W-1:0]    b_sqx_ff, b_sqy_ff;
   logic [DSQ_W-1:0]   c_dsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_cand_ff <= in_cand;
      a_dx_ff   <= abs_diff(query_lon, in_cand.pt.x);
      a_dy_ff   <= abs_diff(query_lat, in_cand.pt.y);
      b_cand_ff <= a_cand_ff;
      b_sqx_ff  <= SQ_W'(a_dx_ff) * SQ_W'(a_dx_ff);
      b_sqy_ff  <= SQ_W'(a_dy_ff) * SQ_W'(a_dy_ff);
      c_cand_ff <= b_cand_ff;
      c_dsq_ff  <= {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   end

   assign out_valid = c_valid_ff;
   assign out_cand  = c_cand_ff;
   assign out_dsq   = c_dsq_ff;
   assign busy      = a_valid_ff | b_valid_ff | c_valid_ff;

endmodule

[hdl/masked_nearest_point_search.sv]
// ----------------------------------------------------------------------------
// Masked nearest point search
// Point table and candidate list in on-chip memories, searched by a linear
// scan for the unmasked point closest to a query position.
// ----------------------------------------------------------------------------
// A point write or a slot write is one transaction and gives no response. A
// query walks the first list_length slots (saturated at 1024) through the slot
// memory, one slot per cycle. The single read port of the slot memory sets
// that pace, and the slot read overlaps the walk itself; after it come the
// point read, the three stages of the squared-distance pipeline, the
// running-minimum update and the response register. One query is in flight
// at a time, and the block takes no request transaction while a query scans.
// Writes may be accepted while a response still waits; a new query waits
// until the response register is free or is being emptied. The memories have
// no reset and need no clearing pass: a query must only touch slots and
// points that were written earlier. Ties keep the point met first.
// csr_wdata sets list_length and may be written only while the block is idle.
// ----------------------------------------------------------------------------
module masked_nearest_point_search import mnps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   mnps_req_if.sink         req_if,
   mnps_rsp_if.source       rsp_if
);

   // Control state.
   mnps_state_type    state_ff, state_in;
   logic [LEN_W-1:0]  list_len_ff;
   logic [LEN_W-1:0]  num_ff, num_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              s1_valid_ff, s2_valid_ff;
   logic              best_found_ff, best_found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic signed [COORD_W-1:0] qlat_ff, qlon_ff;
   mnps_slot_type             slot_rd_ff;
   mnps_point_type            point_rd_ff;
   logic [PIDX_W-1:0]         s2_idx_ff;
   logic [DSQ_W-1:0]          best_dsq_ff;
   mnps_cand_type             best_ff;
   logic                      rsp_found_ff;
   mnps_cand_type             rsp_cand_ff;

   // Memories.
   mnps_point_type point_mem [MAX_POINTS];
   mnps_slot_type  slot_mem  [MAX_SLOTS];

   logic          req_accept, query_accept, rsp_free;
   logic          req_ready, issue_en, scan_done;
   logic          dsq_valid, dsq_busy, dsq_better;
   mnps_cand_type dsq_cand;
   logic [DSQ_W-1:0] dsq_value;
   mnps_cand_type s2_cand;
   logic [LEN_W-1:0] len_sat;

   assign req_accept   = req_if.valid && req_ready;
   assign query_accept = req_accept && (req_if.mode == MODE_QUERY);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign len_sat      = (list_len_ff > LEN_W'(MAX_SLOTS)) ? LEN_W'(MAX_SLOTS)
                                                           : list_len_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs. A query is finished once every slot has been issued and
   // the read and distance stages have drained.
   always_comb begin
      req_ready = 1'b0;
      issue_en  = 1'b0;
      scan_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = (req_if.mode != MODE_QUERY) || rsp_free;
         end
         ST_SCAN: begin
            issue_en  = cnt_ff < num_ff;
            scan_done = !issue_en && !s1_valid_ff && !s2_valid_ff && !dsq_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_if.ready = req_ready;

   // Slot counter and running minimum.
   assign dsq_better = dsq_valid && (!best_found_ff || (dsq_value < best_dsq_ff));

   always_comb begin
      num_in        = num_ff;
      cnt_in        = cnt_ff;
      best_found_in = best_found_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (query_accept) begin
         num_in        = len_sat;
         cnt_in        = '0;
         best_found_in = 1'b0;
      end else if (issue_en) begin
         cnt_in = cnt_ff + LEN_W'(1);
      end
      if (dsq_better) begin
         best_found_in = 1'b1;
      end
      if (scan_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         list_len_ff   <= '0;
         num_ff        <= '0;
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_ff        <= num_in;
         cnt_ff        <= cnt_in;
         s1_valid_ff   <= issue_en;
         s2_valid_ff   <= s1_valid_ff && !slot_rd_ff.masked;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            list_len_ff <= csr_wdata;
         end
      end
   end

   // Query position, held for the whole scan.
   always_ff @(posedge clock) begin
      if (query_accept) begin
         qlat_ff <= req_if.query_lat;
         qlon_ff <= req_if.query_lon;
      end
   end

   // Slot memory: written by slot transactions, read at the slot counter.
   always_ff @(posedge clock) begin
      if (req_accept && (req_if.mode == MODE_WR_SLOT)) begin
         slot_mem[req_if.slot_index] <= '{masked: req_if.slot_masked,
                                          idx:    req_if.point_index};
      end
      slot_rd_ff <= slot_mem[cnt_ff[SIDX_W-1:0]];
   end

   // Point memory: written by point transactions, read at the slot's index.
   always_ff @(posedge clock) begin
      if (req_accept && (req_if.mode == MODE_WR_POINT)) begin
         point_mem[req_if.point_index] <= '{x: req_if.point_x,
                                            y: req_if.point_y,
                                            z: req_if.point_z};
      end
      point_rd_ff <= point_mem[slot_rd_ff.idx];
      s2_idx_ff   <= slot_rd_ff.idx;
   end

   assign s2_cand = '{idx: s2_idx_ff, pt: point_rd_ff};

   mnps_sqdist u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_cand   (s2_cand),
      .query_lat (qlat_ff),
      .query_lon (qlon_ff),
      .out_valid (dsq_valid),
      .out_cand  (dsq_cand),
      .out_dsq   (dsq_value),
      .busy      (dsq_busy)
   );

   // The best candidate so far. A strict compare keeps the earlier point on
   // a tie.
   always_ff @(posedge clock) begin
      if (dsq_better) begin
         best_dsq_ff <= dsq_value;
         best_ff     <= dsq_cand;
      end
   end

   // Response register. With no unmasked candidate every field reads zero.
   always_ff @(posedge clock) begin
      if (scan_done) begin
         rsp_found_ff <= best_found_ff;
         rsp_cand_ff  <= best_found_ff ? best_ff : '0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.found         = rsp_found_ff;
   assign rsp_if.nearest_index = rsp_cand_ff.idx;
   assign rsp_if.nearest_x     = rsp_cand_ff.pt.x;
   assign rsp_if.nearest_y     = rsp_cand_ff.pt.y;
   assign rsp_if.nearest_z     = rsp_cand_ff.pt.z;

   // While idle, nothing may remain in the read or distance stages.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff && !dsq_busy))
      else $error("pipeline active while idle");

   // The slot counter never runs past the saturated list length.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= num_ff)
      else $error("slot counter overran the list length");

   // A query is only taken when the response register can hold its result.
   assert property (@(posedge clock) disable iff (reset)
      query_accept |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("query accepted while a response was still held");

   // The response loads exactly once per query, in the cycle after the scan ends.
   assert property (@(posedge clock) disable iff (reset)
      scan_done |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("response not presented after the scan ended");

endmodule

[verif/mnps_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked nearest point search: verification types and result checker
// Transaction records for both channels and a checker class that keeps its
// own copy of the point table, the candidate list and list_length, works out
// the nearest unmasked point for every accepted query and compares it with
// the response stream in order.
// ----------------------------------------------------------------------------
package mnps_tb_pkg;
   import mnps_pkg::*;

   // The fourth mode code does nothing in the block.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]                mode;
      logic [PIDX_W-1:0]         point_index;
      logic [SIDX_W-1:0]         slot_index;
      logic                      slot_masked;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] query_lat;
      logic signed [COORD_W-1:0] query_lon;
   } search_request_type;

   typedef struct packed {
      logic                      found;
      logic [PIDX_W-1:0]         index;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } nearest_result_type;

   class nearest_point_scoreboard;
      logic signed [COORD_W-1:0] stored_x [MAX_POINTS];
      logic signed [COORD_W-1:0] stored_y [MAX_POINTS];
      logic signed [COORD_W-1:0] stored_z [MAX_POINTS];
      mnps_slot_type             slot_list [MAX_SLOTS];
      logic [LEN_W-1:0]          list_length;
      nearest_result_type        pending_results [$];
      int errors;
      int query_count;
      int found_count;
      int empty_count;

      function new();
         list_length = '0;
      endfunction

      function void set_list_length(logic [LEN_W-1:0] len);
         list_length = len;
      endfunction

      // Magnitude of a - b; the difference of two 32-bit values needs 33 bits,
      // but its magnitude never exceeds 2^32 - 1.
      static function logic [COORD_W-1:0] gap(logic signed [COORD_W-1:0] a,
                                              logic signed [COORD_W-1:0] b);
         logic [COORD_W:0] d;
         logic [COORD_W:0] m;
         d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
         m = d[COORD_W] ? -d : d;
         return m[COORD_W-1:0];
      endfunction

      function nearest_result_type search(logic signed [COORD_W-1:0] lat,
                                          logic signed [COORD_W-1:0] lon);
         nearest_result_type best;
         logic [DSQ_W-1:0] best_dist;
         logic [DSQ_W-1:0] cand_dist;
         logic [COORD_W-1:0] dy;
         logic [COORD_W-1:0] dx;
         mnps_slot_type s;
         int span;
         best = '0;
         best_dist = '0;
         span = (list_length > MAX_SLOTS) ? MAX_SLOTS : int'(list_length);
         for (int i = 0; i < span; i++) begin
            s = slot_list[i];
            if (!s.masked) begin
               dy = gap(lat, stored_y[s.idx]);
               dx = gap(lon, stored_x[s.idx]);
               cand_dist = DSQ_W'(dy) * DSQ_W'(dy) + DSQ_W'(dx) * DSQ_W'(dx);
               // Strictly smaller only, so the first of equal points stays.
               if (!best.found || cand_dist < best_dist) begin
                  best.found = 1'b1;
                  best.index = s.idx;
                  best.x     = stored_x[s.idx];
                  best.y     = stored_y[s.idx];
                  best.z     = stored_z[s.idx];
                  best_dist  = cand_dist;
               end
            end
         end
         return best;
      endfunction

      function void note_request(search_request_type r);
         case (r.mode)
            MODE_WR_POINT: begin
               stored_x[r.point_index] = r.point_x;
               stored_y[r.point_index] = r.point_y;
               stored_z[r.point_index] = r.point_z;
            end
            MODE_WR_SLOT: begin
               slot_list[r.slot_index] = '{masked: r.slot_masked, idx: r.point_index};
            end
            MODE_QUERY: begin
               pending_results.push_back(search(r.query_lat, r.query_lon));
               query_count++;
            end
            default: ;
         endcase
      endfunction

      function void report_field(string name, logic [COORD_W-1:0] want,
                                 logic [COORD_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
                     $time, name, want, got);
         end
      endfunction

      function void check_response(nearest_result_type got);
         nearest_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: response with no query outstanding, expected none, actual %p",
                     $time, got);
            return;
         end
         want = pending_results.pop_front();
         if (want.found)
            found_count++;
         else
            empty_count++;
         report_field("found", COORD_W'(want.found), COORD_W'(got.found));
         report_field("nearest_index", COORD_W'(want.index), COORD_W'(got.index));
         report_field("nearest_x", want.x, got.x);
         report_field("nearest_y", want.y, got.y);
         report_field("nearest_z", want.z, got.z);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

endpackage

[verif/masked_nearest_point_search_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked nearest point search: testbench
// Loads points and candidate slots, sets list_length to a spread of values and
// fires queries at the block. A checker class predicts every response; the
// request and response channels idle and stall at random in several phases,
// and one phase holds the response side off long enough to back up requests.
// ----------------------------------------------------------------------------
module masked_nearest_point_search_tb;
   import mnps_pkg::*;
   import mnps_tb_pkg::*;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
   // A write is done once it is taken, so a short pause after the
   // last response is enough before list_length may change.
   localparam int SETTLE_CYCLES = 8;
   // A full-length scan plus the pipeline, waited out at the very end so that
   // a stray response would still be caught.
   localparam int TAIL_CYCLES   = MAX_SLOTS + 16;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } landmark_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [LEN_W-1:0] csr_wdata;

   mnps_req_if req_ch ();
   mnps_rsp_if rsp_ch ();

   masked_nearest_point_search dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   nearest_point_scoreboard board;

   // Stimulus bookkeeping. A query must never touch a slot or point that was
   // not written, so the testbench tracks which ones exist and only lets
   // slots name points that are already there.
   bit              point_written [MAX_POINTS];
   bit              slot_written [MAX_SLOTS];
   logic [PIDX_W-1:0] written_points [$];
   landmark_type    landmarks [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int items_sent    = 0;
   int noise_sent    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: the ready line is redrawn every cycle from the current
   // stall rate. A hold request turns it off for a counted stretch instead.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Both channels are sampled at the clock edge, before any of this edge's
   // updates land. Each accepted request transaction goes to the checker,
   // which predicts from its own copy of the state; each accepted response
   // transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      search_request_type accepted;
      nearest_result_type observed;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            accepted.mode        = req_ch.mode;
            accepted.point_index = req_ch.point_index;
            accepted.slot_index  = req_ch.slot_index;
            accepted.slot_masked = req_ch.slot_masked;
            accepted.point_x     = req_ch.point_x;
            accepted.point_y     = req_ch.point_y;
            accepted.point_z     = req_ch.point_z;
            accepted.query_lat   = req_ch.query_lat;
            accepted.query_lon   = req_ch.query_lon;
            board.note_request(accepted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed.found = rsp_ch.found;
            observed.index = rsp_ch.nearest_index;
            observed.x     = rsp_ch.nearest_x;
            observed.y     = rsp_ch.nearest_y;
            observed.z     = rsp_ch.nearest_z;
            board.check_response(observed);
         end
      end
   end

   // Coordinates lean toward the extremes and toward a tight cluster around
   // zero, where equal distances and therefore ties are common.
   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(7))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2, 3:    return COORD_W'($urandom_range(6)) - COORD_W'(3);
         default: return $urandom;
      endcase
   endfunction

   // Every field starts out random, so fields that a mode ignores still toggle.
   function automatic search_request_type base_request();
      search_request_type r;
      r.mode        = MODE_UNUSED;
      r.point_index = PIDX_W'($urandom);
      r.slot_index  = SIDX_W'($urandom);
      r.slot_masked = 1'($urandom);
      r.point_x     = $urandom;
      r.point_y     = $urandom;
      r.point_z     = $urandom;
      r.query_lat   = $urandom;
      r.query_lon   = $urandom;
      return r;
   endfunction

   function automatic search_request_type point_item(logic [PIDX_W-1:0] idx,
         logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
         logic signed [COORD_W-1:0] z);
      search_request_type r;
      r = base_request();
      r.mode        = MODE_WR_POINT;
      r.point_index = idx;
      r.point_x     = x;
      r.point_y     = y;
      r.point_z     = z;
      return r;
   endfunction

   function automatic search_request_type slot_item(logic [SIDX_W-1:0] slot,
         logic [PIDX_W-1:0] idx, logic masked);
      search_request_type r;
      r = base_request();
      r.mode        = MODE_WR_SLOT;
      r.slot_index  = slot;
      r.point_index = idx;
      r.slot_masked = masked;
      return r;
   endfunction

   function automatic search_request_type query_item(logic signed [COORD_W-1:0] lat,
                                                     logic signed [COORD_W-1:0] lon);
      search_request_type r;
      r = base_request();
      r.mode      = MODE_QUERY;
      r.query_lat = lat;
      r.query_lon = lon;
      return r;
   endfunction

   function automatic logic [PIDX_W-1:0] some_written_point();
      return written_points[$urandom_range(written_points.size() - 1)];
   endfunction

   // One random transaction. Slot writes mostly land inside the searched part
   // of the list so that they change query answers; half of the queries aim
   // close to a point that was written, the rest go anywhere.
   function automatic search_request_type random_request(int len);
      search_request_type r;
      landmark_type spot;
      int pick;
      int top;
      pick = $urandom_range(99);
      top  = (len + 3 > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : len + 3;
      if (pick < 30) begin
         r = point_item(($urandom_range(1) == 0) ? some_written_point() : PIDX_W'($urandom),
                        random_coord(), random_coord(), random_coord());
      end else if (pick < 58) begin
         r = slot_item(($urandom_range(2) != 0) ? SIDX_W'($urandom_range(top))
                                                : SIDX_W'($urandom),
                       some_written_point(), $urandom_range(3) == 0);
      end else if (pick < 95) begin
         if ($urandom_range(1) == 0) begin
            spot = landmarks[$urandom_range(landmarks.size() - 1)];
            r = query_item(spot.y + COORD_W'($urandom_range(8)) - COORD_W'(4),
                           spot.x + COORD_W'($urandom_range(8)) - COORD_W'(4));
         end else begin
            r = query_item(random_coord(), random_coord());
         end
      end else begin
         r = base_request();
      end
      return r;
   endfunction

   // Offers one request transaction, after a random idle gap, and returns at
   // the edge where it is taken. Valid stays high into the next call.
   task automatic send(input search_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= r.mode;
      req_ch.point_index <= r.point_index;
      req_ch.slot_index  <= r.slot_index;
      req_ch.slot_masked <= r.slot_masked;
      req_ch.point_x     <= r.point_x;
      req_ch.point_y     <= r.point_y;
      req_ch.point_z     <= r.point_z;
      req_ch.query_lat   <= r.query_lat;
      req_ch.query_lon   <= r.query_lon;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      case (r.mode)
         MODE_WR_POINT: begin
            if (!point_written[r.point_index]) begin
               point_written[r.point_index] = 1'b1;
               written_points.push_back(r.point_index);
            end
            landmarks.push_back('{x: r.point_x, y: r.point_y});
         end
         MODE_WR_SLOT: slot_written[r.slot_index] = 1'b1;
         default: ;
      endcase
      if (r.mode == MODE_UNUSED)
         noise_sent++;
      else
         items_sent++;
   endtask

   // Stops offering, waits for every predicted response and then lets the
   // block finish any write still in hand. The first edge lets the checker
   // take in the last accepted transaction before the count is read.
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_list_length(input logic [LEN_W-1:0] len);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.set_list_length(len);
   endtask

   // Fills every slot that the coming list length will search and that was
   // never written, so that no query reads an empty slot.
   task automatic cover_slots(input int len);
      int span;
      span = (len > MAX_SLOTS) ? MAX_SLOTS : len;
      for (int s = 0; s < span; s++)
         if (!slot_written[s])
            send(slot_item(SIDX_W'(s), some_written_point(), $urandom_range(3) == 0));
   endtask

   task automatic run_phase(input int len, input int quota, input int send_pct,
                            input int rsp_pct, input int hold);
      search_request_type r;
      int taken;
      send_idle_pct = send_pct;
      stall_pct     = rsp_pct;
      cover_slots(len);
      wait_until_idle();
      write_list_length(LEN_W'(len));
      hold_request = hold;
      taken = 0;
      while (taken < quota) begin
         r = random_request(len);
         send(r);
         if (r.mode != MODE_UNUSED)
            taken++;
      end
      wait_until_idle();
   endtask

   initial begin
      search_request_type r;
      board = new();
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_UNUSED;
      req_ch.point_index = '0;
      req_ch.slot_index  = '0;
      req_ch.slot_masked = 1'b0;
      req_ch.point_x     = '0;
      req_ch.point_y     = '0;
      req_ch.point_z     = '0;
      req_ch.query_lat   = '0;
      req_ch.query_lon   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty list must report no candidate, and the
      // unused mode code must leave everything alone.
      write_list_length('0);
      send(query_item('0, '0));
      r = base_request();
      send(r);

      // Points at the corners of the coordinate range and at both ends of the
      // table, plus two points at the same spot to check that ties keep the
      // one met first.
      send(point_item('0, COORD_MIN, COORD_MAX, -1));
      send(point_item(PIDX_W'(MAX_POINTS - 1), COORD_MAX, COORD_MIN, COORD_MIN));
      send(point_item(PIDX_W'(1), '0, '0, COORD_MAX));
      send(point_item(PIDX_W'(2), 100, -100, 5));
      send(point_item(PIDX_W'(3), 100, -100, 6));
      send(slot_item('0, PIDX_W'(MAX_POINTS - 1), 1'b1));
      send(slot_item(SIDX_W'(1), '0, 1'b0));
      send(slot_item(SIDX_W'(2), PIDX_W'(2), 1'b0));
      send(slot_item(SIDX_W'(3), PIDX_W'(3), 1'b0));
      send(slot_item(SIDX_W'(4), PIDX_W'(1), 1'b1));
      send(slot_item(SIDX_W'(MAX_SLOTS - 1), PIDX_W'(MAX_POINTS - 1), 1'b0));

      // A list whose only slot is masked has no candidate either.
      wait_until_idle();
      write_list_length(LEN_W'(1));
      send(query_item('0, '0));

      // Opposite corners give distance sums that carry out of 64 bits; the
      // exact spot of the twin points checks the tie rule.
      wait_until_idle();
      write_list_length(LEN_W'(5));
      send(query_item(COORD_MIN, COORD_MAX));
      send(query_item(-100, 100));
      send(query_item(COORD_MAX, COORD_MIN));
      send(query_item('0, '0));
      // Moving the first twin away hands the spot to the second; unmasking a
      // slot brings its point back into play.
      send(point_item(PIDX_W'(2), COORD_MAX, COORD_MAX, 7));
      send(query_item(-100, 100));
      send(slot_item(SIDX_W'(4), PIDX_W'(1), 1'b0));
      send(query_item('0, '0));
      wait_until_idle();

      // Random part, one list length per phase, cycling through the idle and
      // stall patterns. The sixth phase holds responses off for a long
      // stretch while requests keep coming, so the block backs up.
      run_phase(1, 60, 0, 0, 0);
      run_phase($urandom_range(2, 16), 65, 46, 0, 0);
      run_phase($urandom_range(17, 64), 65, 0, 46, 0);
      run_phase($urandom_range(2, 16), 65, 24, 24, 0);
      run_phase($urandom_range(65, 120), 60, 0, 0, 0);
      run_phase($urandom_range(3, 12), 65, 0, 0, 400);
      run_phase($urandom_range(1, 32), 60, 24, 24, 0);

      wait_until_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request transactions and %0d no-op ones, %0d queries",
               items_sent, noise_sent, board.query_count);
      $display("(%0d answered with a point, %0d with none), list lengths 0 to 120.",
               board.found_count, board.empty_count);
      if (board.errors == 0 && board.pending() == 0)
         $display("masked_nearest_point_search_tb: clean");
      else
         $display("masked_nearest_point_search_tb: errors");
      $finish;
   end

   // Safety net well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("%0t: run timed out", $time);
      $display("masked_nearest_point_search_tb: errors");
      $finish;
   end

endmodule
